FILE: sv/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants for the RGBA box blur
// Payload structs, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 3;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SLOT_W  = $clog2(STORE_ROWS);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int RAD_W   = 2;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int SPAN_W  = $clog2(STORE_ROWS + 1);
    localparam int CNT_W   = $clog2(STORE_ROWS * STORE_ROWS + 1);
    localparam int SUM_W   = $clog2(STORE_ROWS * STORE_ROWS * 255 + 1);
    localparam int DIVC_W  = $clog2(SUM_W);
    localparam int PIX_W   = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [7:0]       out_alpha;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             run_last;
        logic             frame_done;
    } t_out_pix;

    typedef struct packed {
        logic write;     // store pixel, latch output ranges
        logic finish;    // advance input position
        logic win_init;  // set up window of current output
        logic read_step; // issue one line store read
        logic div_init;  // clear divider
        logic div_step;  // one quotient bit
        logic out_next;  // next output coordinate
    } t_cmd;

    typedef struct packed {
        logic has_out;
        logic last_read;
        logic div_done;
        logic last_out;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/box_blur_rgba_edge_normalized.sv
// A pixel that completes no output is only written; each completed output
// reads its N-pixel in-frame window (N = 1..49), divides, then awaits ready.
// Throughput: one pixel at a time; bounded by the single line store read port
// (one window pixel per cycle) and the bit-serial divider.
// Reset: synchronous active low; position returns to (0,0), registers to
// radius 1, 640x480. The line store is not cleared.
// ----------------------------------------------------------------------------
// box_blur_rgba_edge_normalized: streaming RGBA box blur, edge normalized
// Raster-order pixels in; window means per channel out, with coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_rgba_edge_normalized import bbr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_pix               i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_pix                   o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    bbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bbr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: sv/bbr_ram.sv
// ----------------------------------------------------------------------------
// bbr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bbr_dpath.sv
// ----------------------------------------------------------------------------
// bbr_dpath: box blur datapath
// Config registers, position counters, line store, window sums, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_dpath import bbr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire t_in_pix               i_in,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_pix                   o_out
);

    logic [RAD_W-1:0]  r_radius;
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;

    logic [COL_W-1:0]  r_x, r_x0, r_x1;
    logic [ROW_W-1:0]  r_y, r_y1;
    logic              r_has_out;

    logic [COL_W-1:0]  r_sx, r_sx0, r_sx1;
    logic [ROW_W-1:0]  r_sy, r_sy1;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_vld;

    logic [SUM_W-1:0]  r_sum [4];
    logic [CNT_W-1:0]  r_rem [4];
    logic [DIVC_W-1:0] r_div_cnt;

    logic [RAD_W-1:0]  rad;
    logic [WID_W-1:0]  w_eff, w_m1;
    logic [HGT_W-1:0]  h_eff, h_m1;
    logic [COL_W-1:0]  rad_c;
    logic [ROW_W-1:0]  rad_r;
    logic              c_last, r_last_row, c_ok, r_ok;
    logic [COL_W-1:0]  x0_in, x1_in;
    logic [ROW_W-1:0]  y0_in, y1_in;
    logic [WID_W-1:0]  sx_hi;
    logic [HGT_W-1:0]  sy_hi;
    logic [COL_W-1:0]  sx0_w, sx1_w;
    logic [ROW_W-1:0]  sy0_w, sy1_w;
    logic [SPAN_W-1:0] nx, ny;
    logic [SLOT_W-1:0] row_dist;
    logic [SLOT_W:0]   slot_t;
    logic [SLOT_W-1:0] slot_rd;
    logic [PIX_W-1:0]  rdata;
    logic [SUM_W-1:0]  n_sum [4];
    logic [CNT_W-1:0]  n_rem [4];

    assign o_cfg_ready = 1'b1;

    // effective register values
    assign rad   = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
    assign w_eff = (r_width == '0) ? WID_W'(1)
                 : ((r_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_width);
    assign h_eff = (r_height == '0) ? HGT_W'(1)
                 : ((r_height > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : r_height);
    assign w_m1  = w_eff - WID_W'(1);
    assign h_m1  = h_eff - HGT_W'(1);
    assign rad_c = COL_W'(rad);
    assign rad_r = ROW_W'(rad);

    // outputs completed by the incoming pixel
    assign c_last     = ({1'b0, r_col} == w_m1);
    assign r_last_row = ({1'b0, r_row} == h_m1);
    assign c_ok  = c_last || (r_col >= rad_c);
    assign r_ok  = r_last_row || (r_row >= rad_r);
    assign x0_in = (r_col >= rad_c) ? (r_col - rad_c) : '0;
    assign x1_in = c_last ? r_col : (r_col - rad_c);
    assign y0_in = (r_row >= rad_r) ? (r_row - rad_r) : '0;
    assign y1_in = r_last_row ? r_row : (r_row - rad_r);

    // window bounds of the current output
    assign sx_hi = {1'b0, r_x} + WID_W'(rad);
    assign sy_hi = {1'b0, r_y} + HGT_W'(rad);
    assign sx0_w = (r_x >= rad_c) ? (r_x - rad_c) : '0;
    assign sy0_w = (r_y >= rad_r) ? (r_y - rad_r) : '0;
    assign sx1_w = (sx_hi < w_eff) ? sx_hi[COL_W-1:0] : w_m1[COL_W-1:0];
    assign sy1_w = (sy_hi < h_eff) ? sy_hi[ROW_W-1:0] : h_m1[ROW_W-1:0];
    assign nx    = SPAN_W'(sx1_w - sx0_w) + SPAN_W'(1);
    assign ny    = SPAN_W'(sy1_w - sy0_w) + SPAN_W'(1);

    // store slot of window row: slot of current row minus row distance, mod rows
    assign row_dist = SLOT_W'(r_row - r_sy);
    assign slot_t   = {1'b0, r_slot} + (SLOT_W+1)'(STORE_ROWS) - {1'b0, row_dist};
    assign slot_rd  = (slot_t >= (SLOT_W+1)'(STORE_ROWS))
                    ? SLOT_W'(slot_t - (SLOT_W+1)'(STORE_ROWS)) : slot_t[SLOT_W-1:0];

    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr ({r_slot, r_col}),
        .i_wdata ({i_in.in_alpha, i_in.in_blue, i_in.in_green, i_in.in_red}),
        .i_re    (i_cmd.read_step),
        .i_raddr ({slot_rd, r_sx}),
        .o_rdata (rdata)
    );

    // restoring divider step, one bit per lane
    always_comb begin
        logic [CNT_W:0] sh;
        for (int k = 0; k < 4; k++) begin
            sh = {r_rem[k], r_sum[k][SUM_W-1]};
            if (sh >= {1'b0, r_cnt}) begin
                n_rem[k] = CNT_W'(sh - {1'b0, r_cnt});
                n_sum[k] = {r_sum[k][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[CNT_W-1:0];
                n_sum[k] = {r_sum[k][SUM_W-2:0], 1'b0};
            end
        end
    end

    // config and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_width  <= WID_W'(640);
            r_height <= HGT_W'(480);
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index == REG_RADIUS || i_cfg_index == REG_WIDTH
                    || i_cfg_index == REG_HEIGHT) begin
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end
        end else if (i_cmd.finish) begin
            if (c_last) begin
                r_col <= '0;
                if (r_last_row) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_slot <= (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                            : r_slot + SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // read issue tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read_step;
        end
    end

    // output iteration, window walk, sums and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_has_out <= c_ok && r_ok;
            r_x0 <= x0_in;
            r_x1 <= x1_in;
            r_y1 <= y1_in;
            r_x  <= x0_in;
            r_y  <= y0_in;
        end else if (i_cmd.out_next) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + ROW_W'(1);
            end else begin
                r_x <= r_x + COL_W'(1);
            end
        end

        if (i_cmd.win_init) begin
            r_sx  <= sx0_w;
            r_sx0 <= sx0_w;
            r_sx1 <= sx1_w;
            r_sy  <= sy0_w;
            r_sy1 <= sy1_w;
            r_cnt <= CNT_W'(nx) * CNT_W'(ny);
        end else if (i_cmd.read_step) begin
            if (r_sx == r_sx1) begin
                r_sx <= r_sx0;
                r_sy <= r_sy + ROW_W'(1);
            end else begin
                r_sx <= r_sx + COL_W'(1);
            end
        end

        if (i_cmd.div_init) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIVC_W'(1);
        end

        for (int k = 0; k < 4; k++) begin
            if (i_cmd.win_init) begin
                r_sum[k] <= '0;
            end else if (r_rd_vld) begin
                r_sum[k] <= r_sum[k] + SUM_W'(rdata[8*k +: 8]);
            end else if (i_cmd.div_step) begin
                r_sum[k] <= n_sum[k];
            end
            if (i_cmd.div_init) begin
                r_rem[k] <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[k] <= n_rem[k];
            end
        end
    end

    assign o_sts.has_out   = r_has_out;
    assign o_sts.last_read = (r_sx == r_sx1) && (r_sy == r_sy1);
    assign o_sts.div_done  = (r_div_cnt == DIVC_W'(SUM_W - 1));
    assign o_sts.last_out  = (r_x == r_x1) && (r_y == r_y1);

    // result fields, quotients sit in the sum registers after division
    assign o_out.out_red    = r_sum[0][7:0];
    assign o_out.out_green  = r_sum[1][7:0];
    assign o_out.out_blue   = r_sum[2][7:0];
    assign o_out.out_alpha  = r_sum[3][7:0];
    assign o_out.out_col    = r_x;
    assign o_out.out_row    = r_y;
    assign o_out.run_last   = (r_x == r_x1) && (r_y == r_y1);
    assign o_out.frame_done = ({1'b0, r_x} == w_m1) && ({1'b0, r_y} == h_m1);

endmodule

`default_nettype wire

FILE: sv/bbr_ctrl.sv
// ----------------------------------------------------------------------------
// bbr_ctrl: box blur controller
// Sequences write, then window read, divide and emit per completed output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ctrl import bbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_WIN   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.has_out) begin
                    n_state = S_WIN;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WIN: begin
                o_cmd.win_init = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
                if (i_sts.last_read) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_sts.last_out) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_WIN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/bbr_checker.sv
// ----------------------------------------------------------------------------
// bbr_checker: port-level checks for the box blur
// Output handshake and sequencing properties seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_checker import bbr_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_out_pix o_out
);

    // a result is held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // one pixel at a time: no new input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // the frame's last output is always the last output of its pixel
    a_frame_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_done |-> o_out.run_last)
        else $error("frame_done without run_last");

    // ready for input right after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

endmodule

bind box_blur_rgba_edge_normalized bbr_checker u_bbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
